// ===== design/vec4_register_packing_allocator_core_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef VEC4_REGISTER_PACKING_ALLOCATOR_CORE_MACROS_SVH
`define VEC4_REGISTER_PACKING_ALLOCATOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, masked while reset is asserted.
`define VRPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds through reset.
`define VRPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define VRPA_ASSERT(lbl, clk, rst_n, prop, msg)
`define VRPA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== design/vrpa_pkg.sv =====
package vrpa_pkg;

  // Grid geometry and fixed field widths
  localparam int NUM_COLS   = 4;
  localparam int CNT_W      = 3;
  localparam int SIZE_W     = 9;
  localparam int CFG_W      = 9;
  localparam int OFFSET_W   = 8;
  localparam int SHIFT_W    = 2;
  localparam int TOP_W      = 9;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;
  localparam int ROWS_RST   = 8;

  // Component count codes
  localparam logic [CNT_W-1:0] COMP_SCALAR = 3'd1;
  localparam logic [CNT_W-1:0] COMP_VEC2   = 3'd2;
  localparam logic [CNT_W-1:0] COMP_VEC4   = 3'd4;

  // Column codes
  localparam logic [SHIFT_W-1:0] COL_X = 2'd0;
  localparam logic [SHIFT_W-1:0] COL_Z = 2'd2;

  // One result, last field in the lowest bits
  typedef struct packed {
    logic [TOP_W-1:0]    top_rows_used;
    logic [SHIFT_W-1:0]  column_shift;
    logic [OFFSET_W-1:0] row_offset;
    logic                placed;
  } res_t;

endpackage

// ===== design/vrpa_place.sv =====
module vrpa_place #(
  parameter int ROW_W = 9
) (
  input  logic                                   start_new,
  input  logic [vrpa_pkg::CNT_W-1:0]             component_count,
  input  logic [vrpa_pkg::SIZE_W-1:0]            row_count,
  input  logic [ROW_W-1:0]                       total_rows,
  input  logic [vrpa_pkg::NUM_COLS-1:0][ROW_W-1:0] fill_i,
  input  logic [ROW_W-1:0]                       top_i,
  input  logic [ROW_W-1:0]                       bottom_i,
  output logic [vrpa_pkg::NUM_COLS-1:0][ROW_W-1:0] fill_o,
  output logic [ROW_W-1:0]                       top_o,
  output logic [ROW_W-1:0]                       bottom_o,
  output vrpa_pkg::res_t                         res
);

  // Signed width that holds limit - fill - size without wrap
  localparam int SW = ((ROW_W > vrpa_pkg::SIZE_W) ? ROW_W : vrpa_pkg::SIZE_W) + 3;

  logic [vrpa_pkg::NUM_COLS-1:0][ROW_W-1:0] fill_e;
  logic [ROW_W-1:0]                         top_e;
  logic [ROW_W-1:0]                         bottom_e;
  logic signed [SW-1:0]                     total_s;
  logic signed [SW-1:0]                     top_s;
  logic signed [SW-1:0]                     bottom_s;
  logic signed [SW-1:0]                     size_s;
  logic signed [SW-1:0]                     limit_s;
  logic signed [SW-1:0]                     spare [vrpa_pkg::NUM_COLS];
  logic [vrpa_pkg::NUM_COLS-1:0]            col_fit;
  logic                                     item_ok;
  logic                                     top_fit;
  logic                                     spill_fit;
  logic                                     pick_ok;
  logic [vrpa_pkg::SHIFT_W-1:0]             pick;
  logic signed [SW-1:0]                     least;
  logic signed [SW-1:0]                     top_sum;
  logic signed [SW-1:0]                     bottom_sum;
  logic [ROW_W-1:0]                         offset;
  logic [vrpa_pkg::SHIFT_W-1:0]             shift;
  logic                                     placed;

  // Apply the start flag: a cleared map before placement
  always_comb begin
    fill_e   = start_new ? '0 : fill_i;
    top_e    = start_new ? '0 : top_i;
    bottom_e = start_new ? '0 : bottom_i;
  end

  // Widen the operands
  assign total_s    = SW'(total_rows);
  assign top_s      = SW'(top_e);
  assign bottom_s   = SW'(bottom_e);
  assign size_s     = SW'(row_count);
  assign top_sum    = top_s + size_s;
  assign bottom_sum = bottom_s + size_s;
  assign limit_s    = (bottom_e == '0) ? total_s : (total_s - bottom_s);

  assign item_ok = (row_count != '0) && (component_count >= vrpa_pkg::COMP_SCALAR) &&
                   (component_count <= vrpa_pkg::COMP_VEC4);
  assign top_fit = (component_count >= vrpa_pkg::COMP_VEC2) && (top_sum <= total_s);
  assign spill_fit = (component_count == vrpa_pkg::COMP_VEC2) &&
                     (SW'(fill_e[vrpa_pkg::COL_Z]) + bottom_sum <= total_s);

  // Room left in each candidate column; only z and w once a spill exists
  always_comb begin
    for (int c = 0; c < vrpa_pkg::NUM_COLS; c++) begin
      spare[c]   = limit_s - SW'(fill_e[c]) - size_s;
      col_fit[c] = (spare[c] >= 0) &&
                   ((bottom_e == '0) || (c >= int'(vrpa_pkg::COL_Z)));
    end
  end

  // Best fit: least room left, ties to the lower column
  always_comb begin
    pick_ok = 1'b0;
    pick    = vrpa_pkg::COL_X;
    least   = '0;
    for (int c = 0; c < vrpa_pkg::NUM_COLS; c++) begin
      if (col_fit[c] && (!pick_ok || (spare[c] < least))) begin
        pick_ok = 1'b1;
        pick    = vrpa_pkg::SHIFT_W'(c);
        least   = spare[c];
      end
    end
  end

  // Place the item: whole rows, then vec2 spill, then scalar best fit
  always_comb begin
    fill_o   = fill_e;
    top_o    = top_e;
    bottom_o = bottom_e;
    offset   = '0;
    shift    = vrpa_pkg::COL_X;
    placed   = 1'b0;
    priority if (item_ok && top_fit) begin
      placed = 1'b1;
      offset = top_e;
      top_o  = ROW_W'(top_sum);
      for (int c = 0; c < vrpa_pkg::NUM_COLS; c++) begin
        if (c < int'(component_count)) begin
          fill_o[c] = ROW_W'(top_sum);
        end
      end
    end else if (item_ok && spill_fit) begin
      placed   = 1'b1;
      bottom_o = ROW_W'(bottom_sum);
      offset   = ROW_W'(total_s - bottom_sum);
      shift    = vrpa_pkg::COL_Z;
    end else if (item_ok && (component_count == vrpa_pkg::COMP_SCALAR) && pick_ok) begin
      placed       = 1'b1;
      offset       = fill_e[pick];
      shift        = pick;
      fill_o[pick] = ROW_W'(SW'(fill_e[pick]) + size_s);
    end else begin
      placed = 1'b0;
    end
  end

  // Pack the result
  always_comb begin
    res.placed        = placed;
    res.row_offset    = vrpa_pkg::OFFSET_W'(offset);
    res.column_shift  = shift;
    res.top_rows_used = vrpa_pkg::TOP_W'(top_o);
  end

endmodule

// ===== design/vec4_register_packing_allocator_core.sv =====
// Vec4 register packing allocator. Each transfer on the in_ stream is one
// variable (component count 1..4, row count) to place in a grid of total_rows
// rows by four columns; each transfer on the out_ stream is its placement:
// placed flag, first row, first column and the whole rows claimed from the top.
// Vec3/vec4 (and vec2 that fit) take whole rows from the top, further vec2
// spill into z/w from the bottom, scalars take the best-fit column. Send the
// items sorted largest first and set in_tuser on the first item of a set to
// clear the map. An item passes an input register and the combinational
// placement logic into the output register; one item per cycle is sustained
// while out_tready is high, limited by the map update loop through placement.
// Write cfg_wdata (rows, saturated to MAX_ROWS) only while the block is idle.
`include "vec4_register_packing_allocator_core_macros.svh"

module vec4_register_packing_allocator_core #(
  parameter int MAX_ROWS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration: total_rows
  input  logic                            cfg_we,
  input  logic [vrpa_pkg::CFG_W-1:0]      cfg_wdata,
  // Input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] component_count, [11:3] row_count, [15:12] zero
  input  logic [vrpa_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] start_new
  input  logic                            in_tuser,
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] placed, [8:1] row_offset, [10:9] column_shift, [19:11] top_rows_used,
  // [23:20] zero
  output logic [vrpa_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int CAP   = (MAX_ROWS < 511) ? MAX_ROWS : 511;
  localparam int ROW_W = $clog2(((CAP > vrpa_pkg::ROWS_RST) ? CAP : vrpa_pkg::ROWS_RST) + 1);

  logic [ROW_W-1:0]                          total_rows_r;
  logic [ROW_W-1:0]                          total_rows_nxt;
  logic [vrpa_pkg::NUM_COLS-1:0][ROW_W-1:0]  fill_r;
  logic [vrpa_pkg::NUM_COLS-1:0][ROW_W-1:0]  fill_nxt;
  logic [ROW_W-1:0]                          top_rows_r;
  logic [ROW_W-1:0]                          top_rows_nxt;
  logic [ROW_W-1:0]                          bottom_r;
  logic [ROW_W-1:0]                          bottom_nxt;
  logic                                      s1_valid_r;
  logic                                      s1_start_r;
  logic [vrpa_pkg::CNT_W-1:0]                s1_count_r;
  logic [vrpa_pkg::SIZE_W-1:0]               s1_size_r;
  logic                                      out_valid_r;
  vrpa_pkg::res_t                            out_res_r;
  vrpa_pkg::res_t                            res_nxt;
  logic                                      advance;
  logic                                      in_xfer;

  // Stage handshake: place when the output register is free or draining
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // Saturate the row count on write
  always_comb begin
    if (int'(cfg_wdata) > MAX_ROWS) begin
      total_rows_nxt = ROW_W'(MAX_ROWS);
    end else begin
      total_rows_nxt = ROW_W'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_rows_r <= ROW_W'(vrpa_pkg::ROWS_RST);
    end else if (cfg_we) begin
      total_rows_r <= total_rows_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_start_r <= in_tuser;
      s1_count_r <= in_tdata[vrpa_pkg::CNT_W-1:0];
      s1_size_r  <= in_tdata[vrpa_pkg::CNT_W +: vrpa_pkg::SIZE_W];
    end
  end

  // Placement logic
  vrpa_place #(
    .ROW_W (ROW_W)
  ) u_place (
    .start_new       (s1_start_r),
    .component_count (s1_count_r),
    .row_count       (s1_size_r),
    .total_rows      (total_rows_r),
    .fill_i          (fill_r),
    .top_i           (top_rows_r),
    .bottom_i        (bottom_r),
    .fill_o          (fill_nxt),
    .top_o           (top_rows_nxt),
    .bottom_o        (bottom_nxt),
    .res             (res_nxt)
  );

  // Allocation map: commit on each advance out of the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      top_rows_r <= '0;
      bottom_r   <= '0;
    end else if (advance) begin
      fill_r     <= fill_nxt;
      top_rows_r <= top_rows_nxt;
      bottom_r   <= bottom_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = vrpa_pkg::OUT_DATA_W'(out_res_r);

  // Checks
  `VRPA_ASSERT(a_s1_held, clk, rst_n, s1_valid_r && !advance |=> s1_valid_r,
               "input stage item dropped")
  `VRPA_ASSERT(a_fail_keeps_top, clk, rst_n,
               advance && !res_nxt.placed && !s1_start_r |=> top_rows_r == $past(top_rows_r),
               "failed placement changed top rows")
  `VRPA_ASSERT(a_spill_grows, clk, rst_n,
               advance && !s1_start_r |=> bottom_r >= $past(bottom_r),
               "spill rows shrank without a clear")
  `VRPA_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid_r && !s1_valid_r,
                      "stages not empty after reset")

endmodule
